FILE: src/slgp_pkg.sv
// slgp_pkg: shared constants, types and helpers for the serial line gain parser
// no dependencies; imported by every slgp module
`timescale 1ns / 1ps

package slgp_pkg;

  localparam int LINE_MAX        = 256;
  localparam int FRACTION_DIGITS = 4;
  localparam int FIELD_COUNT     = 4;

  localparam int BYTE_W     = 8;
  localparam int VALUE_W    = 30;
  localparam int SUM_W      = VALUE_W + 4;
  localparam int LENGTH_W   = 8;
  localparam int OUT_VALUES = 4;
  localparam int COUNT_W    = $clog2(LINE_MAX);
  localparam int FIELD_W    = $clog2(FIELD_COUNT + 1);
  localparam int POS_W      = $clog2(FRACTION_DIGITS + 1);

  function automatic longint pow10_const(int n);
    longint p;
    p = 1;
    for (int i = 0; i < n; i++) begin
      p = p * 10;
    end
    return p;
  endfunction

  localparam longint SCALE       = pow10_const(FRACTION_DIGITS);
  localparam longint VALUE_CAP   = (longint'(1) << VALUE_W) - 1;
  localparam longint LIMIT_RAW   = 65536 * SCALE - 1;
  localparam longint LIMIT_WIDE  = (LIMIT_RAW > VALUE_CAP) ? VALUE_CAP : LIMIT_RAW;
  localparam logic [VALUE_W-1:0] VALUE_LIMIT = VALUE_W'(LIMIT_WIDE);

  localparam logic [BYTE_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [BYTE_W-1:0] CHAR_NINE  = 8'h39;
  localparam logic [BYTE_W-1:0] CHAR_POINT = 8'h2E;
  localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'h20;

  localparam logic [BYTE_W-1:0] FIRST_TERM_RESET  = 8'd13;
  localparam logic [BYTE_W-1:0] SECOND_TERM_RESET = 8'd10;

  typedef enum logic {
    REG_FIRST_TERM  = 1'b0,
    REG_SECOND_TERM = 1'b1
  } reg_index_t;

  typedef enum logic [1:0] {
    STATUS_DONE     = 2'd0,
    STATUS_BAD_TERM = 2'd1,
    STATUS_TOO_LONG = 2'd2
  } line_status_t;

  typedef struct packed {
    line_status_t                         status;
    logic [OUT_VALUES-1:0][VALUE_W-1:0]   values;
    logic [LENGTH_W-1:0]                  length;
  } result_t;

  // weight of the fraction digit at position pos
  function automatic logic [VALUE_W-1:0] frac_weight(logic [POS_W-1:0] pos);
    logic [VALUE_W-1:0] w;
    w = '0;
    for (int i = 0; i < FRACTION_DIGITS; i++) begin
      if (pos == POS_W'(i)) begin
        w = VALUE_W'(pow10_const(FRACTION_DIGITS - 1 - i));
      end
    end
    return w;
  endfunction

  function automatic logic [LENGTH_W-1:0] sat_length(logic [COUNT_W-1:0] c);
    logic [COUNT_W+LENGTH_W-1:0] wide;
    wide = (COUNT_W + LENGTH_W)'(c);
    if (wide > (COUNT_W + LENGTH_W)'(255)) begin
      return '1;
    end
    return wide[LENGTH_W-1:0];
  endfunction

endpackage

FILE: src/slgp_value_update.sv
// slgp_value_update: folds one decimal digit into a fixed point field value
// saturating at the package value limit; uses slgp_pkg
`timescale 1ns / 1ps

module slgp_value_update (
  input  logic [slgp_pkg::VALUE_W-1:0] value_in,
  input  logic [3:0]                   digit,
  input  logic                         in_fraction,
  input  logic [slgp_pkg::POS_W-1:0]   frac_pos,
  output logic [slgp_pkg::VALUE_W-1:0] value_out
);
  import slgp_pkg::*;

  logic [SUM_W-1:0] v_wide;
  logic [SUM_W-1:0] d_wide;
  logic [SUM_W-1:0] sum;

  assign v_wide = SUM_W'(value_in);
  assign d_wide = SUM_W'(digit);

  always_comb begin
    if (in_fraction) begin
      sum = v_wide + d_wide * SUM_W'(frac_weight(frac_pos));
    end else begin
      sum = (v_wide << 3) + (v_wide << 1) + d_wide * SUM_W'(SCALE);
    end
    if (sum > SUM_W'(VALUE_LIMIT)) begin
      value_out = VALUE_LIMIT;
    end else begin
      value_out = sum[VALUE_W-1:0];
    end
  end

endmodule

FILE: src/slgp_line_parser.sv
// slgp_line_parser: line state, terminator check and field parsing per byte
// uses slgp_pkg and slgp_value_update
`timescale 1ns / 1ps

module slgp_line_parser (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          proc,
  input  logic [slgp_pkg::BYTE_W-1:0]   rx_byte,
  input  logic [slgp_pkg::BYTE_W-1:0]   first_term,
  input  logic [slgp_pkg::BYTE_W-1:0]   second_term,
  output logic                          res_valid,
  output slgp_pkg::result_t             res
);
  import slgp_pkg::*;

  logic [COUNT_W-1:0]  byte_count;
  logic                terminator_started;
  logic                in_fraction;
  logic [POS_W-1:0]    fraction_position;
  logic [FIELD_W-1:0]  field_number;
  logic [VALUE_W-1:0]  field_values [FIELD_COUNT];

  logic                is_digit;
  logic                field_open;
  logic                take_digit;
  logic                clear;
  logic                line_full;
  logic [VALUE_W-1:0]  cur_value;
  logic [VALUE_W-1:0]  new_value;
  logic [$clog2(FIELD_COUNT > 1 ? FIELD_COUNT : 2)-1:0] field_sel;

  assign is_digit   = rx_byte inside {[CHAR_ZERO:CHAR_NINE]};
  assign field_open = field_number < FIELD_W'(FIELD_COUNT);
  assign field_sel  = $bits(field_sel)'(field_number);
  assign cur_value  = field_open ? field_values[field_sel] : '0;
  assign take_digit = is_digit && field_open &&
                      (!in_fraction || fraction_position < POS_W'(FRACTION_DIGITS));
  assign line_full  = byte_count == COUNT_W'(LINE_MAX - 1);

  slgp_value_update u_value_update (
    .value_in    (cur_value),
    .digit       (rx_byte[3:0]),
    .in_fraction (in_fraction),
    .frac_pos    (fraction_position),
    .value_out   (new_value)
  );

  always_comb begin
    res_valid  = 1'b0;
    clear      = 1'b0;
    res        = '0;
    res.status = STATUS_DONE;
    if (terminator_started) begin
      res_valid = 1'b1;
      clear     = 1'b1;
      if (rx_byte == second_term) begin
        for (int j = 0; j < OUT_VALUES; j++) begin
          if (j < FIELD_COUNT) begin
            res.values[j] = field_values[j];
          end
        end
        res.length = sat_length(byte_count);
      end else begin
        res.status = STATUS_BAD_TERM;
      end
    end else if (rx_byte != first_term && line_full) begin
      res_valid  = 1'b1;
      clear      = 1'b1;
      res.status = STATUS_TOO_LONG;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count         <= '0;
      terminator_started <= 1'b0;
      in_fraction        <= 1'b0;
      fraction_position  <= '0;
      field_number       <= '0;
      for (int i = 0; i < FIELD_COUNT; i++) begin
        field_values[i] <= '0;
      end
    end else if (proc) begin
      if (clear) begin
        byte_count         <= '0;
        terminator_started <= 1'b0;
        in_fraction        <= 1'b0;
        fraction_position  <= '0;
        field_number       <= '0;
        for (int i = 0; i < FIELD_COUNT; i++) begin
          field_values[i] <= '0;
        end
      end else if (rx_byte == first_term) begin
        terminator_started <= 1'b1;
      end else begin
        byte_count <= byte_count + COUNT_W'(1);
        if (take_digit) begin
          field_values[field_sel] <= new_value;
          if (in_fraction) begin
            fraction_position <= fraction_position + POS_W'(1);
          end
        end else if (rx_byte == CHAR_POINT) begin
          in_fraction <= 1'b1;
        end else if (rx_byte == CHAR_SPACE) begin
          if (field_open) begin
            field_number <= field_number + FIELD_W'(1);
          end
          in_fraction       <= 1'b0;
          fraction_position <= '0;
        end
      end
    end
  end

endmodule

FILE: src/serial_line_gain_parser_unit.sv
// serial_line_gain_parser_unit: top level with input stage, terminator registers
// and result register; uses slgp_pkg and slgp_line_parser
`timescale 1ns / 1ps

// Takes one received byte per transfer and assembles a line ended by the two
// terminator bytes (CR then LF after reset), parsing up to four space-separated
// unsigned decimal numbers into fixed point scaled by 10000, saturating at
// 655359999. One result per completed line (status 0) or per error (status 1
// for a wrong byte after the first terminator, 2 for a line too long), with
// values and length zero on errors. A byte is taken every cycle while in_stall
// is low; the byte goes into the input register, and its result is formed by
// one pass of the line parser into the result register.
// Terminator registers are written through cfg_write/cfg_index/cfg_data; the
// user must write them only while the block is idle; the block does not enforce it.
module serial_line_gain_parser_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [slgp_pkg::BYTE_W-1:0]     rx_byte,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [1:0]                      line_status,
  output logic [slgp_pkg::VALUE_W-1:0]    value_first,
  output logic [slgp_pkg::VALUE_W-1:0]    value_second,
  output logic [slgp_pkg::VALUE_W-1:0]    value_third,
  output logic [slgp_pkg::VALUE_W-1:0]    value_fourth,
  output logic [slgp_pkg::LENGTH_W-1:0]   line_length,
  input  logic                            cfg_write,
  input  logic                            cfg_index,
  input  logic [slgp_pkg::BYTE_W-1:0]     cfg_data
);
  import slgp_pkg::*;

  logic [BYTE_W-1:0] first_term;
  logic [BYTE_W-1:0] second_term;
  logic              s1_full;
  logic [BYTE_W-1:0] s1_byte;
  logic              out_free;
  logic              proc;
  logic              res_valid;
  result_t           res;
  result_t           out_res;

  assign out_free = !out_valid || !out_stall;
  assign proc     = s1_full && out_free;
  assign in_stall = s1_full && !out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      first_term  <= FIRST_TERM_RESET;
      second_term <= SECOND_TERM_RESET;
    end else if (cfg_write) begin
      case (reg_index_t'(cfg_index))
        REG_FIRST_TERM:  first_term  <= cfg_data;
        REG_SECOND_TERM: second_term <= cfg_data;
        default: ;
      endcase
    end
  end

  // input stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_full <= 1'b0;
    end else if (!in_stall) begin
      s1_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_byte <= rx_byte;
    end
  end

  slgp_line_parser u_line_parser (
    .clk         (clk),
    .rst         (rst),
    .proc        (proc),
    .rx_byte     (s1_byte),
    .first_term  (first_term),
    .second_term (second_term),
    .res_valid   (res_valid),
    .res         (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= proc && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (proc && res_valid) begin
      out_res <= res;
    end
  end

  assign line_status  = out_res.status;
  assign value_first  = out_res.values[0];
  assign value_second = out_res.values[1];
  assign value_third  = out_res.values[2];
  assign value_fourth = out_res.values[3];
  assign line_length  = out_res.length;

endmodule
